### rtl/spd_pkg.sv
// Shared types and constants for the shortest-path block.
// Used by spd_ctrl, spd_datapath and shortest_path_dijkstra; no dependencies.
package spd_pkg;

    localparam int SPD_MAX_VERTICES = 16;
    localparam int SPD_WEIGHT_BITS  = 16;

    localparam int VERTEX_W    = 4;
    localparam int WEIGHT_IN_W = 16;
    localparam int COUNT_W     = 5;
    localparam int DIST_W      = 20;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
    localparam logic [DIST_W-1:0]  DIST_MAX    = 20'hFFFFF;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef struct packed {
        logic latch;
        logic clr_step;
        logic add_read;
        logic add_write1;
        logic add_write2;
        logic init_start;
        logic init_step;
        logic first_round;
        logic relax_step;
        logic next_round;
        logic out_start;
        logic out_read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic add_ok;
        logic clr_done;
        logic init_done;
        logic src_ok;
        logic relax_done;
        logic found;
        logic out_free;
        logic out_last;
    } stat_t;

endpackage

### rtl/spd_ctrl.sv
// Sequencer for the shortest-path block: edge updates, clearing sweep, runs.
// Depends on spd_pkg for the command and status structs and the item kinds.
module spd_ctrl
    import spd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          kind,
    input  stat_t               stat,
    output logic                in_ready,
    output cmd_t                cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CLEAR   = 9'b000000010,
        S_ADD_RD  = 9'b000000100,
        S_ADD_CMP = 9'b000001000,
        S_ADD_WR2 = 9'b000010000,
        S_INIT    = 9'b000100000,
        S_RELAX   = 9'b001000000,
        S_OUT_RD  = 9'b010000000,
        S_OUT_LD  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.latch  = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_ADD)
                    begin
                        if (stat.add_ok)
                        begin
                            state_next = S_ADD_RD;
                        end
                    end
                    else if (kind == KIND_RUN)
                    begin
                        cmd.init_start = 1'b1;
                        state_next     = S_INIT;
                    end
                    else if (kind == KIND_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADD_RD:
            begin
                cmd.add_read = 1'b1;
                state_next   = S_ADD_CMP;
            end
            S_ADD_CMP:
            begin
                cmd.add_write1 = 1'b1;
                state_next     = S_ADD_WR2;
            end
            S_ADD_WR2:
            begin
                cmd.add_write2 = 1'b1;
                state_next     = S_IDLE;
            end
            S_INIT:
            begin
                cmd.init_step = !stat.init_done;
                if (stat.init_done)
                begin
                    if (stat.src_ok)
                    begin
                        cmd.first_round = 1'b1;
                        state_next      = S_RELAX;
                    end
                    else
                    begin
                        cmd.out_start = 1'b1;
                        state_next    = S_OUT_RD;
                    end
                end
            end
            S_RELAX:
            begin
                cmd.relax_step = 1'b1;
                if (stat.relax_done)
                begin
                    if (stat.found)
                    begin
                        cmd.next_round = 1'b1;
                    end
                    else
                    begin
                        cmd.out_start = 1'b1;
                        state_next    = S_OUT_RD;
                    end
                end
            end
            S_OUT_RD:
            begin
                cmd.out_read = 1'b1;
                state_next   = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/spd_datapath.sv
// Datapath: edge weight memory, distance memory, settled mask, sweep counters,
// relaxation and minimum search, output register. Depends on spd_pkg.
module spd_datapath
    import spd_pkg::*;
#(
    parameter int MAX_VERTICES = SPD_MAX_VERTICES,
    parameter int WEIGHT_BITS  = SPD_WEIGHT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [COUNT_W-1:0]     cfg_wr_data,
    input  logic [VERTEX_W-1:0]    first_vertex,
    input  logic [VERTEX_W-1:0]    second_vertex,
    input  logic [WEIGHT_IN_W-1:0] edge_weight,
    input  logic [VERTEX_W-1:0]    source,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [VERTEX_W-1:0]    vertex,
    output logic [DIST_W-1:0]      distance,
    output logic                   reachable,
    output logic                   last
);

    localparam int VW         = $clog2(MAX_VERTICES);
    localparam int AW         = 2 * VW;
    localparam int EDGE_DEPTH = 1 << AW;
    localparam int SUM_W      = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
    localparam logic [32:0]      WEIGHT_MAX   = (33'd1 << WEIGHT_BITS) - 33'd1;
    localparam logic [SUM_W-1:0] SUM_DIST_MAX = SUM_W'(DIST_MAX);

    logic [WEIGHT_BITS:0] edge_mem [EDGE_DEPTH];
    logic [DIST_W:0]      dist_mem [MAX_VERTICES];

    logic [COUNT_W-1:0]     vertex_count_reg;
    logic [AW-1:0]          clr_reg;
    logic [VW:0]            idx_reg;
    logic                   p_reg;
    logic                   found_reg;
    logic [MAX_VERTICES-1:0] settled_reg;
    logic                   out_valid_reg;

    logic [VW-1:0]          a_reg;
    logic [VW-1:0]          b_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [VERTEX_W-1:0]    src_reg;
    logic [VW:0]            n_reg;
    logic                   upd_reg;
    logic [VW-1:0]          p_idx_reg;
    logic [VW-1:0]          sel_reg;
    logic [DIST_W-1:0]      dist_sel_reg;
    logic [VW-1:0]          min_idx_reg;
    logic [DIST_W-1:0]      min_dist_reg;
    logic [WEIGHT_BITS:0]   edge_q_reg;
    logic [DIST_W:0]        dist_q_reg;
    logic [VERTEX_W-1:0]    vertex_reg;
    logic [DIST_W-1:0]      distance_reg;
    logic                   reachable_reg;
    logic                   last_reg;

    logic [VW:0]            n_cur;
    logic [32:0]            w_wide;
    logic [WEIGHT_BITS-1:0] w_sat;
    logic                   upd_now;
    logic                   relax_issue;
    logic                   edge_we;
    logic [AW-1:0]          edge_waddr;
    logic [WEIGHT_BITS:0]   edge_wdata;
    logic                   edge_re;
    logic [AW-1:0]          edge_raddr;
    logic                   dist_we;
    logic [VW-1:0]          dist_waddr;
    logic [DIST_W:0]        dist_wdata;
    logic                   dist_re;
    logic                   src_hit;
    logic                   settled_hit;
    logic [SUM_W-1:0]       cand_sum;
    logic [DIST_W-1:0]      cand;
    logic                   relax_upd;
    logic                   new_reached;
    logic [DIST_W-1:0]      new_dist;
    logic                   take_min;

    // vertex count in use
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            n_cur = (VW+1)'(1);
        end
        else if (32'(vertex_count_reg) > 32'(MAX_VERTICES))
        begin
            n_cur = (VW+1)'(MAX_VERTICES);
        end
        else
        begin
            n_cur = (VW+1)'(vertex_count_reg);
        end
    end

    assign w_wide = 33'(edge_weight);
    assign w_sat  = (w_wide > WEIGHT_MAX) ? WEIGHT_BITS'(WEIGHT_MAX) : WEIGHT_BITS'(w_wide);

    assign upd_now     = !edge_q_reg[WEIGHT_BITS] || (w_reg < edge_q_reg[WEIGHT_BITS-1:0]);
    assign relax_issue = cmd.relax_step && (idx_reg != n_reg);

    // relax stage: edge and distance of p_idx_reg are in the read registers
    assign settled_hit = settled_reg[p_idx_reg];
    assign cand_sum    = SUM_W'(dist_sel_reg) + SUM_W'(edge_q_reg[WEIGHT_BITS-1:0]);
    assign cand        = (cand_sum > SUM_DIST_MAX) ? DIST_MAX : DIST_W'(cand_sum);
    assign relax_upd   = p_reg && edge_q_reg[WEIGHT_BITS] && !settled_hit
                         && (!dist_q_reg[DIST_W] || (cand < dist_q_reg[DIST_W-1:0]));
    assign new_reached = dist_q_reg[DIST_W] || relax_upd;
    assign new_dist    = relax_upd ? cand : dist_q_reg[DIST_W-1:0];
    assign take_min    = p_reg && new_reached && !settled_hit
                         && (!found_reg || (new_dist < min_dist_reg));

    always_comb
    begin
        edge_we    = 1'b0;
        edge_waddr = clr_reg;
        edge_wdata = '0;
        priority if (cmd.clr_step)
        begin
            edge_we = 1'b1;
        end
        else if (cmd.add_write1)
        begin
            edge_we    = upd_now;
            edge_waddr = {a_reg, b_reg};
            edge_wdata = {1'b1, w_reg};
        end
        else if (cmd.add_write2)
        begin
            edge_we    = upd_reg;
            edge_waddr = {b_reg, a_reg};
            edge_wdata = {1'b1, w_reg};
        end
    end

    assign edge_re    = cmd.add_read || relax_issue;
    assign edge_raddr = cmd.add_read ? {a_reg, b_reg} : {sel_reg, idx_reg[VW-1:0]};

    assign src_hit    = (32'(idx_reg) == 32'(src_reg));
    assign dist_we    = cmd.init_step || relax_upd;
    assign dist_waddr = cmd.init_step ? idx_reg[VW-1:0] : p_idx_reg;
    assign dist_wdata = cmd.init_step ? {src_hit, DIST_W'(0)} : {1'b1, cand};
    assign dist_re    = relax_issue || cmd.out_read;

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        if (edge_re)
        begin
            edge_q_reg <= edge_mem[edge_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (dist_re)
        begin
            dist_q_reg <= dist_mem[idx_reg[VW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= COUNT_RESET;
            clr_reg          <= '0;
            idx_reg          <= '0;
            p_reg            <= 1'b0;
            found_reg        <= 1'b0;
            settled_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vertex_count_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.init_start || cmd.first_round || cmd.next_round || cmd.out_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.init_step || relax_issue || cmd.out_load)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.first_round || cmd.next_round)
            begin
                p_reg     <= 1'b0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.relax_step)
                begin
                    p_reg <= relax_issue;
                end
                if (take_min)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.init_start)
            begin
                settled_reg <= '0;
            end
            else if (cmd.first_round)
            begin
                settled_reg[VW'(src_reg)] <= 1'b1;
            end
            else if (cmd.next_round)
            begin
                settled_reg[min_idx_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            a_reg   <= VW'(first_vertex);
            b_reg   <= VW'(second_vertex);
            w_reg   <= w_sat;
            src_reg <= source;
            n_reg   <= n_cur;
        end
        if (cmd.add_write1)
        begin
            upd_reg <= upd_now;
        end
        if (relax_issue)
        begin
            p_idx_reg <= idx_reg[VW-1:0];
        end
        if (take_min)
        begin
            min_idx_reg  <= p_idx_reg;
            min_dist_reg <= new_dist;
        end
        if (cmd.first_round)
        begin
            sel_reg      <= VW'(src_reg);
            dist_sel_reg <= '0;
        end
        else if (cmd.next_round)
        begin
            sel_reg      <= min_idx_reg;
            dist_sel_reg <= min_dist_reg;
        end
        if (cmd.out_load)
        begin
            vertex_reg    <= VERTEX_W'(idx_reg[VW-1:0]);
            distance_reg  <= dist_q_reg[DIST_W] ? dist_q_reg[DIST_W-1:0] : '0;
            reachable_reg <= dist_q_reg[DIST_W];
            last_reg      <= stat.out_last;
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.add_ok     = (32'(first_vertex) < 32'(n_cur)) && (32'(second_vertex) < 32'(n_cur));
        stat.clr_done   = &clr_reg;
        stat.init_done  = (idx_reg == n_reg);
        stat.src_ok     = (32'(src_reg) < 32'(n_reg));
        stat.relax_done = (idx_reg == n_reg) && !p_reg;
        stat.found      = found_reg;
        stat.out_free   = !out_valid_reg || out_ready;
        stat.out_last   = ((32'(idx_reg) + 32'd1) == 32'(n_reg));
    end

    assign out_valid = out_valid_reg;
    assign vertex    = vertex_reg;
    assign distance  = distance_reg;
    assign reachable = reachable_reg;
    assign last      = last_reg;

endmodule

### rtl/shortest_path_dijkstra.sv
// Single-source shortest paths over a small undirected weighted graph.
// Top level: joins spd_ctrl and spd_datapath; depends on spd_pkg.
//
// Items are taken one at a time; in_ready is high only while the sequencer is
// idle, and the output register lets a new item in while a result waits. After
// reset and after each clear item the edge memory is swept one entry a cycle
// over all 2**(2*clog2(MAX_VERTICES)) entries (256 at 16 vertices), with
// in_ready low. An add-edge item is read, compared and written in both
// directions over the one write port of the edge memory; kind 3 items and
// out-of-range edges leave the sequencer idle. A run over n vertices
// initializes the distance memory, then, if the source is in range, sweeps
// the edges of each settled vertex (one edge memory read per cycle,
// relaxation and the next minimum search done in the same sweep), and then
// loads one result per vertex, held back by any output stall.
module shortest_path_dijkstra
    import spd_pkg::*;
#(
    parameter int MAX_VERTICES = SPD_MAX_VERTICES,
    parameter int WEIGHT_BITS  = SPD_WEIGHT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [COUNT_W-1:0]     cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic [VERTEX_W-1:0]    first_vertex,
    input  logic [VERTEX_W-1:0]    second_vertex,
    input  logic [WEIGHT_IN_W-1:0] edge_weight,
    input  logic [VERTEX_W-1:0]    source,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VERTEX_W-1:0]    vertex,
    output logic [DIST_W-1:0]      distance,
    output logic                   reachable,
    output logic                   last
);

    cmd_t  cmd;
    stat_t stat;

    spd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    spd_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .edge_weight   (edge_weight),
        .source        (source),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .vertex        (vertex),
        .distance      (distance),
        .reachable     (reachable),
        .last          (last)
    );

`ifndef ASSERT_OFF
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == KIND_RUN)) |=> !in_ready)
        else $error("run transfer did not make the block busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result register loaded while a result is pending");

    a_edge_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.add_write1, cmd.add_write2, cmd.add_read}))
        else $error("conflicting edge memory commands");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && stat.out_last) |=> (in_ready && out_valid && last))
        else $error("final result did not return the block to idle");
`endif

endmodule
